>>> rtl/assert_macros.svh
// assertion macros for the rtl, included by the sorter top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("property check failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

>>> rtl/isort_pkg.sv
// shared types and constants for the insertion sorter
package isort_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_ITEMS_DEF = 64;

    typedef logic signed [DATA_W-1:0] data_t;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic load;
        logic drain;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

endpackage

>>> rtl/insertion_sorter.sv
// top level of the streaming insertion sorter
//
//  channel | handshake        | payload
//  --------+------------------+--------------------------------------------
//  input   | start, busy      | sample_value, ends_set
//  result  | strobe           | sorted_value, final_result, truncated
//
// a sample beat is taken when start is high and busy is low; all cells compare and shift at once
// after the closing beat the chain drains one entry per cycle through cell 0,
// so every entry of the set is emitted while busy is high
// busy is low again in the cycle after the final result
// reset clears the fill count, overflow flag and state; no clearing pass
// the receiver cannot stall, results are strobed for one cycle each
`include "assert_macros.svh"

module insertion_sorter #(
    parameter int MAX_ITEMS = isort_pkg::MAX_ITEMS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  isort_pkg::data_t sample_value,
    input  logic             ends_set,
    output logic             strobe,
    output isort_pkg::data_t sorted_value,
    output logic             final_result,
    output logic             truncated
);
    import isort_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_ITEMS);
    localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic             overflow_reg, overflow_next;

    logic       accept;
    logic       room;
    cell_ctrl_t ctrl;

    data_t chain_value   [MAX_ITEMS];
    logic  chain_greater [MAX_ITEMS];

    assign accept     = start && !busy;
    assign room       = fill_reg < FULL;
    assign ctrl.load  = accept && room;
    assign ctrl.drain = (state_reg == ST_EMIT);

    genvar i;
    generate
        for (i = 0; i < MAX_ITEMS; i++)
        begin : g_cell
            data_t lower_v;
            logic  lower_g;
            data_t upper_v;

            if (i == 0)
            begin : g_first
                assign lower_v = '0;
                assign lower_g = 1'b0;
            end
            else
            begin : g_mid
                assign lower_v = chain_value[i-1];
                assign lower_g = chain_greater[i-1];
            end

            if (i == MAX_ITEMS - 1)
            begin : g_top
                assign upper_v = '0;
            end
            else
            begin : g_below
                assign upper_v = chain_value[i+1];
            end

            isort_cell u_cell (
                .clk           (clk),
                .ctrl          (ctrl),
                .occupied      (CNT_W'(i) < fill_reg),
                .sample        (sample_value),
                .lower_value   (lower_v),
                .lower_greater (lower_g),
                .upper_value   (upper_v),
                .value         (chain_value[i]),
                .greater       (chain_greater[i])
            );
        end
    endgenerate

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        remain_next   = remain_reg;
        overflow_next = overflow_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (room)
                        fill_next = fill_reg + ONE;
                    else
                        overflow_next = 1'b1;
                    if (ends_set)
                    begin
                        state_next  = ST_EMIT;
                        remain_next = room ? (fill_reg + ONE) : fill_reg;
                    end
                end
            end
            ST_EMIT:
            begin
                remain_next = remain_reg - ONE;
                if (remain_reg == ONE)
                begin
                    state_next    = ST_LOAD;
                    fill_next     = '0;
                    overflow_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            fill_reg     <= '0;
            remain_reg   <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            remain_reg   <= remain_next;
            overflow_reg <= overflow_next;
        end
    end

    assign busy         = (state_reg == ST_EMIT);
    assign strobe       = (state_reg == ST_EMIT);
    assign sorted_value = chain_value[0];
    assign final_result = strobe && (remain_reg == ONE);
    assign truncated    = overflow_reg;

    // closing beat starts the drain in the next cycle
    `ASSERT_PROP(a_close_emits, clk, rst_n, (accept && ends_set) |=> strobe)
    // drain runs without gaps until the final result
    `ASSERT_PROP(a_no_gap, clk, rst_n, (strobe && !final_result) |=> strobe)
    // after the final result the block is free again
    `ASSERT_PROP(a_final_frees, clk, rst_n, (strobe && final_result) |=> !busy)
    // fill count never exceeds capacity
    `ASSERT_NEVER(a_fill_range, clk, rst_n, fill_reg > FULL)

endmodule

>>> rtl/isort_cell.sv
// one cell of the insertion chain: holds a single sorted entry
module isort_cell (
    input  logic                clk,
    input  isort_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  isort_pkg::data_t    sample,
    input  isort_pkg::data_t    lower_value,
    input  logic                lower_greater,
    input  isort_pkg::data_t    upper_value,
    output isort_pkg::data_t    value,
    output logic                greater
);
    import isort_pkg::*;

    data_t value_reg;
    data_t value_next;

    assign greater = occupied && (value_reg > sample);
    assign value   = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.load)
        begin
            if (lower_greater)
                value_next = lower_value;
            else if (greater || !occupied)
                value_next = sample;
        end
        else if (ctrl.drain)
        begin
            value_next = upper_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule
